[src/reader_response_frame_parser_defines.svh]
// ----------------------------------------------------------------------------
// Reader response frame parser assertion macros
// Shared concurrent assertion wrappers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef READER_RESPONSE_FRAME_PARSER_DEFINES_SVH
`define READER_RESPONSE_FRAME_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
`define RRFP_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define RRFP_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RRFP_ASSERT_IMP(label, ante, cons, msg)
`define RRFP_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

[src/rrfp_pkg.sv]
// ----------------------------------------------------------------------------
// Reader response frame parser package
// Frame layout constants, limits and result kind codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrfp_pkg;

   typedef logic [7:0] octet_type;
   typedef logic [2:0] kind_type;

   localparam int unsigned MAX_FRAME_BYTES = 255;
   localparam int unsigned MAX_ID_BYTES    = 64;

   localparam octet_type HEAD_BYTE    = 8'hAA;
   localparam octet_type END_BYTE     = 8'hDD;
   localparam octet_type CMD_TAG_READ = 8'h22;
   localparam octet_type TYPE_NOTICE  = 8'h02;
   localparam octet_type CMD_WRITE    = 8'h49;
   localparam octet_type CMD_ERROR    = 8'hFF;

   localparam octet_type FRAME_OVERHEAD = 8'd7;
   localparam octet_type ID_OVERHEAD    = 8'd5;
   localparam octet_type ID_START       = 8'd8;

   localparam octet_type POS_TYPE   = 8'd1;
   localparam octet_type POS_CMD    = 8'd2;
   localparam octet_type POS_LEN_HI = 8'd3;
   localparam octet_type POS_LEN_LO = 8'd4;
   localparam octet_type POS_RSSI   = 8'd5;

   localparam kind_type KIND_TAG_ID    = 3'd0;
   localparam kind_type KIND_TAG_EMPTY = 3'd1;
   localparam kind_type KIND_TAG_LONG  = 3'd2;
   localparam kind_type KIND_WRITE_ACK = 3'd3;
   localparam kind_type KIND_ERROR     = 3'd4;

endpackage

[src/reader_response_frame_parser.sv]
// A single-result frame shows its beat in the cycle after the end byte is taken.
// A tag read passes through ST_READ, which reads the frame memory, and then
// ST_DATA, which presents the registered id byte once the output is free; each
// further id byte repeats both states. Link bytes are taken one per cycle while
// no tag id readout is running and no result beat is waiting.
// Synchronous reset empties the frame and the output; memory contents stay.
// ----------------------------------------------------------------------------
// Reader response frame parser
// Collects length-prefixed reader frames in a byte memory and emits results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "reader_response_frame_parser_defines.svh"

module reader_response_frame_parser
   import rrfp_pkg::*;
#(
   parameter int unsigned FRAME_LIMIT = MAX_FRAME_BYTES,
   parameter int unsigned ID_LIMIT    = MAX_ID_BYTES
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_result_kind,
   output logic [7:0] rsp_payload_byte,
   output logic [7:0] rsp_signal_strength,
   output logic       rsp_last_of_run
);

   localparam logic [1:0] ST_RECV = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_DATA = 2'd2;

   logic [1:0] state_ff, state_in;
   octet_type  count_ff, count_in;
   octet_type  type_ff, type_in;
   octet_type  cmd_ff, cmd_in;
   octet_type  len_hi_ff, len_hi_in;
   octet_type  plen_ff, plen_in;
   octet_type  total_ff, total_in;
   octet_type  rssi_ff, rssi_in;
   octet_type  rd_ptr_ff, rd_ptr_in;
   octet_type  end_ff, end_in;

   logic       rsp_valid_ff, rsp_valid_in;
   kind_type   kind_ff, kind_in;
   octet_type  payload_ff, payload_in;
   octet_type  strength_ff, strength_in;
   logic       last_ff, last_in;

   octet_type  frame_store [256];
   octet_type  mem_rd_data_ff;
   logic       mem_we;
   logic       mem_rd_en;

   logic       out_free;
   logic       req_take;
   logic [16:0] len_total;
   octet_type  id_len;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_RECV) && out_free;
   assign req_take  = req_valid && req_ready;
   assign len_total = {1'b0, len_hi_ff, req_rx_byte} + 17'(FRAME_OVERHEAD);
   assign id_len    = plen_ff - ID_OVERHEAD;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      type_in     = type_ff;
      cmd_in      = cmd_ff;
      len_hi_in   = len_hi_ff;
      plen_in     = plen_ff;
      total_in    = total_ff;
      rssi_in     = rssi_ff;
      rd_ptr_in   = rd_ptr_ff;
      end_in      = end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in     = kind_ff;
      payload_in  = payload_ff;
      strength_in = strength_ff;
      last_in     = last_ff;
      mem_we      = 1'b0;
      mem_rd_en   = 1'b0;

      case (state_ff)
         ST_RECV: begin
            if (req_take && (count_ff != 8'd0 || req_rx_byte == HEAD_BYTE)) begin
               mem_we   = 1'b1;
               count_in = count_ff + 8'd1;
               if (count_ff == POS_TYPE) type_in = req_rx_byte;
               if (count_ff == POS_CMD) cmd_in = req_rx_byte;
               if (count_ff == POS_LEN_HI) len_hi_in = req_rx_byte;
               if (count_ff == POS_RSSI) rssi_in = req_rx_byte;
               if (count_ff == POS_LEN_LO) begin
                  plen_in  = req_rx_byte;
                  total_in = len_total[7:0];
                  if (len_total > 17'(FRAME_LIMIT)) begin
                     count_in = 8'd0;
                  end
               end else if (count_ff >= POS_RSSI && count_ff + 8'd1 == total_ff) begin
                  count_in = 8'd0;
                  if (req_rx_byte == END_BYTE) begin
                     if (cmd_ff == CMD_TAG_READ && type_ff == TYPE_NOTICE) begin
                        if (plen_ff <= ID_OVERHEAD) begin
                           rsp_valid_in = 1'b1;
                           kind_in      = KIND_TAG_EMPTY;
                           payload_in   = 8'd0;
                           strength_in  = rssi_ff;
                           last_in      = 1'b1;
                        end else if (id_len > 8'(ID_LIMIT)) begin
                           rsp_valid_in = 1'b1;
                           kind_in      = KIND_TAG_LONG;
                           payload_in   = 8'd0;
                           strength_in  = rssi_ff;
                           last_in      = 1'b1;
                        end else begin
                           rd_ptr_in = ID_START;
                           end_in    = id_len + ID_START - 8'd1;
                           state_in  = ST_READ;
                        end
                     end else if (cmd_ff == CMD_WRITE) begin
                        rsp_valid_in = 1'b1;
                        kind_in      = KIND_WRITE_ACK;
                        payload_in   = 8'd0;
                        strength_in  = 8'd0;
                        last_in      = 1'b1;
                     end else if (cmd_ff == CMD_ERROR) begin
                        rsp_valid_in = 1'b1;
                        kind_in      = KIND_ERROR;
                        payload_in   = rssi_ff;
                        strength_in  = 8'd0;
                        last_in      = 1'b1;
                     end
                  end
               end
            end
         end
         ST_READ: begin
            mem_rd_en = 1'b1;
            state_in  = ST_DATA;
         end
         ST_DATA: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_TAG_ID;
               payload_in   = mem_rd_data_ff;
               strength_in  = rssi_ff;
               last_in      = (rd_ptr_ff == end_ff);
               if (rd_ptr_ff == end_ff) begin
                  state_in = ST_RECV;
               end else begin
                  rd_ptr_in = rd_ptr_ff + 8'd1;
                  state_in  = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_RECV;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RECV;
         count_ff     <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff     <= type_in;
      cmd_ff      <= cmd_in;
      len_hi_ff   <= len_hi_in;
      plen_ff     <= plen_in;
      total_ff    <= total_in;
      rssi_ff     <= rssi_in;
      rd_ptr_ff   <= rd_ptr_in;
      end_ff      <= end_in;
      kind_ff     <= kind_in;
      payload_ff  <= payload_in;
      strength_ff <= strength_in;
      last_ff     <= last_in;
   end

   // Writes happen only while receiving and reads only during readout, so the
   // two ports never touch the same entry in one cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_store[count_ff] <= req_rx_byte;
      end
      if (mem_rd_en) begin
         mem_rd_data_ff <= frame_store[rd_ptr_ff];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = kind_ff;
   assign rsp_payload_byte    = payload_ff;
   assign rsp_signal_strength = strength_ff;
   assign rsp_last_of_run     = last_ff;

   `RRFP_ASSERT_IMP(a_ready_only_receiving, req_ready, state_ff == ST_RECV, "ready outside receive")
   `RRFP_ASSERT_IMP(a_count_below_total, count_ff > POS_LEN_LO, count_ff < total_ff, "count passed frame total")
   `RRFP_ASSERT_IMP(a_ptr_in_id_range, state_ff != ST_RECV, rd_ptr_ff >= ID_START && rd_ptr_ff <= end_ff, "read pointer outside id bytes")
   `RRFP_ASSERT_NXT(a_readout_beat, state_ff == ST_DATA && out_free, rsp_valid && rsp_result_kind == KIND_TAG_ID, "id beat not presented")

endmodule

[tb/tb_reader_response_frame_parser.sv]
// ----------------------------------------------------------------------------
// Reader response frame parser testbench
// Feeds link bytes as noise and as length-prefixed frames of every type,
// including the length and id-count limits, bad end bytes and dropped
// lengths. A built-in frame tracker predicts each result beat, and a checker
// compares every accepted beat field by field. Both channels idle at random,
// and the result side is held off for a long stretch once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_reader_response_frame_parser;
   import rrfp_pkg::*;

   typedef struct packed {
      kind_type  kind;
      octet_type payload;
      octet_type rssi;
      logic      last;
   } reader_result_type;

   localparam int RANDOM_FILL        = -1;
   localparam int RANDOM_LINK_BYTES  = 40;
   localparam int LONG_HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES       = 20;
   localparam int WATCHDOG_LIMIT     = 2000;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic [2:0] rsp_result_kind;
   logic [7:0] rsp_payload_byte;
   logic [7:0] rsp_signal_strength;
   logic       rsp_last_of_run;

   octet_type         rx_frame [256];
   int unsigned       rx_count = 0;
   reader_result_type pending_results[$];

   int unsigned link_bytes_sent    = 0;
   int          error_count        = 0;
   int          quiet_cycles       = 0;
   int          long_hold_requests = 0;
   int          long_holds_started = 0;
   int          rsp_stall_left     = 0;
   bit          req_gaps_on        = 1'b0;
   bit          rsp_stalls_on      = 1'b0;

   reader_response_frame_parser uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_signal_strength (rsp_signal_strength),
      .rsp_last_of_run     (rsp_last_of_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(25, 60);
   endfunction

   task automatic push_result(input kind_type kind, input octet_type payload,
                              input octet_type rssi, input logic last);
      reader_result_type item;
      item.kind    = kind;
      item.payload = payload;
      item.rssi    = rssi;
      item.last    = last;
      pending_results.push_back(item);
   endtask

   task automatic predict_link_byte(input octet_type b);
      int unsigned param_len;
      int unsigned frame_total;
      int unsigned id_count;
      octet_type   rssi;
      if (rx_count == 0 && b != HEAD_BYTE) return;
      rx_frame[rx_count] = b;
      rx_count++;
      if (rx_count <= POS_LEN_LO) return;
      param_len   = {rx_frame[POS_LEN_HI], rx_frame[POS_LEN_LO]};
      frame_total = param_len + FRAME_OVERHEAD;
      if (frame_total > MAX_FRAME_BYTES) begin
         rx_count = 0;
         return;
      end
      if (rx_count != frame_total) return;
      rx_count = 0;
      if (b != END_BYTE) return;
      rssi = rx_frame[POS_RSSI];
      if (rx_frame[POS_CMD] == CMD_TAG_READ && rx_frame[POS_TYPE] == TYPE_NOTICE) begin
         if (param_len <= ID_OVERHEAD) begin
            push_result(KIND_TAG_EMPTY, 8'h00, rssi, 1'b1);
         end else if (param_len - ID_OVERHEAD > MAX_ID_BYTES) begin
            push_result(KIND_TAG_LONG, 8'h00, rssi, 1'b1);
         end else begin
            id_count = param_len - ID_OVERHEAD;
            for (int unsigned i = 0; i < id_count; i++) begin
               push_result(KIND_TAG_ID, rx_frame[ID_START + i], rssi, i + 1 == id_count);
            end
         end
      end else if (rx_frame[POS_CMD] == CMD_WRITE) begin
         push_result(KIND_WRITE_ACK, 8'h00, 8'h00, 1'b1);
      end else if (rx_frame[POS_CMD] == CMD_ERROR) begin
         push_result(KIND_ERROR, rssi, 8'h00, 1'b1);
      end
   endtask

   task automatic send_link_byte(input octet_type b);
      int idle;
      idle = req_gaps_on ? pick_idle_cycles() : 0;
      if (idle > 0) begin
         req_valid   <= 1'b0;
         req_rx_byte <= octet_type'($urandom);
         repeat (idle) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_link_byte(b);
      link_bytes_sent++;
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_frame(input octet_type ftype, input octet_type cmd,
                             input int unsigned param_len, input octet_type end_byte,
                             input int fill);
      octet_type frame_bytes[$];
      frame_bytes.push_back(HEAD_BYTE);
      frame_bytes.push_back(ftype);
      frame_bytes.push_back(cmd);
      frame_bytes.push_back(octet_type'(param_len >> 8));
      frame_bytes.push_back(octet_type'(param_len));
      if (param_len + FRAME_OVERHEAD <= MAX_FRAME_BYTES) begin
         for (int unsigned i = 0; i < param_len; i++) begin
            frame_bytes.push_back(fill < 0 ? octet_type'($urandom) : octet_type'(fill));
         end
         frame_bytes.push_back(octet_type'($urandom));
         frame_bytes.push_back(end_byte);
      end
      foreach (frame_bytes[i]) send_link_byte(frame_bytes[i]);
   endtask

   task automatic wait_results_drained();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic octet_type bad_end_byte();
      return END_BYTE ^ octet_type'($urandom_range(1, 255));
   endfunction

   task automatic test_directed_frames();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      send_link_byte(8'h00);
      send_link_byte(8'hFF);
      send_frame(8'h01, CMD_WRITE, 0, END_BYTE, RANDOM_FILL);
      send_frame(8'h01, CMD_ERROR, 1, END_BYTE, 8'h00);
      send_frame(TYPE_NOTICE, CMD_TAG_READ, ID_OVERHEAD + 1, END_BYTE, 8'hFF);
      send_frame(TYPE_NOTICE, CMD_TAG_READ, 0, END_BYTE, RANDOM_FILL);
      send_frame(TYPE_NOTICE, CMD_TAG_READ, ID_OVERHEAD, END_BYTE, 8'h00);
      send_frame(TYPE_NOTICE, CMD_TAG_READ, ID_OVERHEAD + 2, bad_end_byte(), RANDOM_FILL);
      send_frame(8'h01, 8'h27, 1, END_BYTE, RANDOM_FILL);
      send_frame(TYPE_NOTICE, CMD_TAG_READ, 16'hFFFF, END_BYTE, RANDOM_FILL);
   endtask

   task automatic test_size_limits();
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      send_frame(TYPE_NOTICE, CMD_TAG_READ, MAX_ID_BYTES + ID_OVERHEAD, END_BYTE, RANDOM_FILL);
      send_frame(TYPE_NOTICE, CMD_TAG_READ, MAX_ID_BYTES + ID_OVERHEAD + 1, END_BYTE,
                 RANDOM_FILL);
      send_frame(TYPE_NOTICE, CMD_TAG_READ, MAX_FRAME_BYTES - FRAME_OVERHEAD, END_BYTE,
                 RANDOM_FILL);
      send_frame(8'h01, CMD_ERROR, MAX_FRAME_BYTES - FRAME_OVERHEAD + 1, END_BYTE,
                 RANDOM_FILL);
   endtask

   task automatic test_output_backpressure();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      long_hold_requests++;
      send_frame(TYPE_NOTICE, CMD_TAG_READ, 20, END_BYTE, RANDOM_FILL);
      send_frame(8'h01, CMD_WRITE, 2, END_BYTE, RANDOM_FILL);
      send_frame(8'h01, CMD_ERROR, 3, END_BYTE, RANDOM_FILL);
      send_frame(TYPE_NOTICE, CMD_TAG_READ, 15, END_BYTE, RANDOM_FILL);
   endtask

   task automatic test_drain_pause();
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      send_frame(TYPE_NOTICE, CMD_TAG_READ, 12, END_BYTE, RANDOM_FILL);
      send_frame(8'h03, CMD_ERROR, 1, END_BYTE, RANDOM_FILL);
      stop_sending();
      wait_results_drained();
      send_frame(8'h01, CMD_WRITE, 0, END_BYTE, RANDOM_FILL);
      send_frame(TYPE_NOTICE, CMD_TAG_READ, 8, END_BYTE, RANDOM_FILL);
   endtask

   task automatic test_random_frames();
      int unsigned start_count;
      int          pick;
      octet_type   cmd_codes[3];
      cmd_codes   = '{CMD_TAG_READ, CMD_WRITE, CMD_ERROR};
      start_count = link_bytes_sent;
      while (link_bytes_sent - start_count < RANDOM_LINK_BYTES) begin
         req_gaps_on   = ($urandom_range(0, 3) != 0);
         rsp_stalls_on = ($urandom_range(0, 3) != 0);
         pick          = $urandom_range(0, 99);
         if (pick < 40) begin
            send_frame(TYPE_NOTICE, CMD_TAG_READ, $urandom_range(0, 16), END_BYTE,
                       RANDOM_FILL);
         end else if (pick < 45) begin
            send_frame(TYPE_NOTICE, CMD_TAG_READ, $urandom_range(0, 75), END_BYTE,
                       RANDOM_FILL);
         end else if (pick < 57) begin
            send_frame(octet_type'($urandom), CMD_WRITE, $urandom_range(0, 8), END_BYTE,
                       RANDOM_FILL);
         end else if (pick < 69) begin
            send_frame(octet_type'($urandom), CMD_ERROR, $urandom_range(0, 8), END_BYTE,
                       RANDOM_FILL);
         end else if (pick < 75) begin
            send_frame(octet_type'($urandom), octet_type'($urandom), $urandom_range(0, 10),
                       END_BYTE, RANDOM_FILL);
         end else if (pick < 81) begin
            send_frame(octet_type'($urandom), CMD_TAG_READ, $urandom_range(0, 10), END_BYTE,
                       RANDOM_FILL);
         end else if (pick < 87) begin
            send_frame(TYPE_NOTICE, cmd_codes[$urandom_range(0, 2)], $urandom_range(0, 10),
                       bad_end_byte(), RANDOM_FILL);
         end else if (pick < 93) begin
            send_frame(TYPE_NOTICE, cmd_codes[$urandom_range(0, 2)],
                       $urandom_range(MAX_FRAME_BYTES - FRAME_OVERHEAD + 1, 16'hFFFF),
                       END_BYTE, RANDOM_FILL);
         end else begin
            repeat ($urandom_range(1, 4)) send_link_byte(octet_type'($urandom));
         end
      end
   endtask

   always @(posedge clock) begin
      if (long_holds_started != long_hold_requests) begin
         rsp_ready          <= 1'b0;
         rsp_stall_left     <= LONG_HOLD_CYCLES;
         long_holds_started <= long_hold_requests;
      end else if (rsp_stall_left > 0) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= pick_idle_cycles();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      reader_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat, kind %0d payload %0h", $time,
                     rsp_result_kind, rsp_payload_byte);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_result_kind !== want.kind) begin
               $display("%0t: result_kind expected %0d, got %0d", $time, want.kind,
                        rsp_result_kind);
               error_count++;
            end
            if (rsp_payload_byte !== want.payload) begin
               $display("%0t: payload_byte expected %0h, got %0h", $time, want.payload,
                        rsp_payload_byte);
               error_count++;
            end
            if (rsp_signal_strength !== want.rssi) begin
               $display("%0t: signal_strength expected %0h, got %0h", $time, want.rssi,
                        rsp_signal_strength);
               error_count++;
            end
            if (rsp_last_of_run !== want.last) begin
               $display("%0t: last_of_run expected %0b, got %0b", $time, want.last,
                        rsp_last_of_run);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat on either channel for %0d cycles", $time, quiet_cycles);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_size_limits();
      test_output_backpressure();
      test_drain_pause();
      test_random_frames();
      stop_sending();
      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
